@@ design/elfls_pkg.sv @@
`default_nettype none
package elfls_pkg;

	// Default depth of the segment store.
	localparam int MAX_SEGMENTS_DEF = 16;
	// Page size is fixed at 4096 bytes.
	localparam int PAGE_BITS = 12;
	localparam logic [63:0] PAGE_MASK = 64'h0000_0000_0000_0FFF;
	localparam int PAGE_NUM_W = 64 - PAGE_BITS;

	// Header field values that a valid image must carry.
	localparam logic [31:0] ELF_SIGNATURE = 32'h464C_457F;
	localparam logic [7:0] ELF_CLASS64 = 8'd2;
	localparam logic [7:0] ELF_DATA_LSB = 8'd1;
	localparam logic [7:0] ELF_IDENT_VER = 8'd1;
	localparam logic [31:0] ELF_FILE_VER = 32'd1;
	localparam logic [15:0] ELF_MACHINE = 16'd62;
	localparam logic [15:0] ELF_EXEC_TYPE = 16'd2;
	localparam logic [15:0] ELF_PHDR_SIZE = 16'd56;
	localparam logic [63:0] ELF_MIN_LENGTH = 64'd64;
	localparam logic [31:0] SEG_TYPE_LOAD = 32'd1;
	localparam logic [63:0] SPAN_LIMIT_RESET = 64'd268435456;

	// Configuration register indexes.
	localparam logic [1:0] CFG_IMAGE_LENGTH = 2'd0;
	localparam logic [1:0] CFG_SPAN_LIMIT = 2'd1;

	typedef enum logic [1:0] {
		ACT_HEADER = 2'd0,
		ACT_ENTRY = 2'd1,
		ACT_FINISH = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [4:0] {
		ERR_NONE = 5'd0,
		ERR_TRUNCATED = 5'd1,
		ERR_MAGIC = 5'd2,
		ERR_CLASS = 5'd3,
		ERR_DATA = 5'd4,
		ERR_VERSION = 5'd5,
		ERR_MACHINE = 5'd6,
		ERR_TYPE = 5'd7,
		ERR_ENTRY_SIZE = 5'd8,
		ERR_NO_SEGMENTS = 5'd9,
		ERR_TABLE_BOUNDS = 5'd10,
		ERR_TOO_MANY = 5'd11,
		ERR_FILE_SIZE = 5'd12,
		ERR_OVERFLOW = 5'd13,
		ERR_OUTSIDE_FILE = 5'd14,
		ERR_OVERLAP = 5'd15,
		ERR_SPAN = 5'd16,
		ERR_ENTRY_POINT = 5'd17
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_ENT,
		ST_RND,
		ST_SCAN,
		ST_FIN,
		ST_FSCAN
	} state_t;

	typedef struct packed {
		logic [1:0] action;
		logic [31:0] type_word;
		logic [31:0] file_version;
		logic [23:0] ident_bytes;
		logic [15:0] machine_code;
		logic [15:0] object_type;
		logic [15:0] entry_size;
		logic [15:0] entry_count;
		logic [63:0] address;
		logic [63:0] offset;
		logic [63:0] stored_size;
		logic [63:0] mem_size;
	} in_item_t;

	typedef struct packed {
		logic [4:0] status;
		logic run_done;
		logic accepted;
		logic [63:0] load_base;
		logic [63:0] load_end;
		logic [63:0] span_base;
		logic [63:0] span_end;
		logic [4:0] segment_count;
	} out_item_t;

	typedef struct packed {
		logic [63:0] image_length;
		logic [63:0] span_limit;
	} cfg_t;

	// One classified request waiting between front and back.
	typedef struct packed {
		action_t kind;
		logic loadable;
		in_item_t item;
	} queue_item_t;

	typedef struct packed {
		logic [PAGE_NUM_W-1:0] page_first;
		logic [PAGE_NUM_W-1:0] page_limit;
		logic [63:0] start;
		logic [63:0] length;
	} seg_t;

	typedef struct packed {
		logic pop;
		logic emit;
		logic run_done;
		logic clear_run;
		logic set_err;
		err_t err;
		logic store;
	} back_ctl_t;

endpackage
`default_nettype wire

@@ design/elfls_front.sv @@
`default_nettype none
module elfls_front
	import elfls_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire in_item_t in_data,
	output logic head_valid,
	output queue_item_t head,
	input wire logic head_pop
);

	queue_item_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	queue_item_t classified;

	// Classify the incoming request before it enters the queue.
	always_comb begin
		classified.kind = action_t'(in_data.action);
		classified.loadable = (in_data.type_word == SEG_TYPE_LOAD) && (in_data.mem_size != 64'd0);
		classified.item = in_data;
	end

	assign in_stall = (count_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign head_valid = (count_q != 2'd0);
	assign head = slot_q[rd_ptr_q];

	// Queue storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= classified;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (head_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, head_pop};
		end
	end

endmodule
`default_nettype wire

@@ design/elfls_back.sv @@
`default_nettype none
module elfls_back
	import elfls_pkg::*;
#(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire logic head_valid,
	input wire queue_item_t head,
	output logic head_pop,
	output logic out_valid,
	input wire logic out_stall,
	output out_item_t out_data
);

	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_SEGMENTS);

	seg_t seg_mem [MAX_SEGMENTS];
	seg_t rd_q;

	state_t st_q, st_d;
	back_ctl_t ctl;
	in_item_t cur_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] rd_idx_q;
	logic cmp_vld_q;
	logic [63:0] lowest_q, highest_q, entry_point_q;
	logic [4:0] sticky_q;
	logic header_valid_q;
	logic [64:0] mem_sum_q;
	logic [63:0] rend_q;
	logic out_valid_q;
	out_item_t out_q;

	logic out_free;
	logic active;
	err_t hdr_err, ent_err, rnd_err;
	logic [64:0] tbl_sum, file_sum, mem_sum, rnd_sum;
	logic [63:0] base, span_diff;
	logic ent_hit, fin_hit, scan_done;
	logic [4:0] sticky_n;
	logic [CW-1:0] total_n;
	logic [63:0] lowest_n, highest_n;

	assign out_free = !out_valid_q || !out_stall;
	assign active = (sticky_q == 5'd0) && header_valid_q;

	// Header checks; the first check that fails gives the error.
	always_comb begin
		tbl_sum = {1'b0, cur_q.offset} + (65'(cur_q.entry_count) * 65'd56);
		if (cfg.image_length < ELF_MIN_LENGTH) hdr_err = ERR_TRUNCATED;
		else if (cur_q.type_word != ELF_SIGNATURE) hdr_err = ERR_MAGIC;
		else if (cur_q.ident_bytes[7:0] != ELF_CLASS64) hdr_err = ERR_CLASS;
		else if (cur_q.ident_bytes[15:8] != ELF_DATA_LSB) hdr_err = ERR_DATA;
		else if (cur_q.ident_bytes[23:16] != ELF_IDENT_VER ||
			cur_q.file_version != ELF_FILE_VER) hdr_err = ERR_VERSION;
		else if (cur_q.machine_code != ELF_MACHINE) hdr_err = ERR_MACHINE;
		else if (cur_q.object_type != ELF_EXEC_TYPE) hdr_err = ERR_TYPE;
		else if (cur_q.entry_size != ELF_PHDR_SIZE) hdr_err = ERR_ENTRY_SIZE;
		else if (cur_q.entry_count == 16'd0) hdr_err = ERR_NO_SEGMENTS;
		else if (tbl_sum[64] || tbl_sum[63:0] > cfg.image_length) hdr_err = ERR_TABLE_BOUNDS;
		else hdr_err = ERR_NONE;
	end

	// Segment count, size, overflow and file bound checks.
	always_comb begin
		file_sum = {1'b0, cur_q.offset} + {1'b0, cur_q.stored_size};
		mem_sum = {1'b0, cur_q.address} + {1'b0, cur_q.mem_size};
		if (total_q >= MAX_COUNT) ent_err = ERR_TOO_MANY;
		else if (cur_q.stored_size > cur_q.mem_size) ent_err = ERR_FILE_SIZE;
		else if (file_sum[64]) ent_err = ERR_OVERFLOW;
		else if (file_sum[63:0] > cfg.image_length) ent_err = ERR_OUTSIDE_FILE;
		else if (mem_sum[64]) ent_err = ERR_OVERFLOW;
		else ent_err = ERR_NONE;
	end

	// Round the segment end up to a page; page-align the base and take the span.
	always_comb begin
		rnd_sum = {1'b0, mem_sum_q[63:0]} + {1'b0, PAGE_MASK};
		rnd_err = rnd_sum[64] ? ERR_OVERFLOW : ERR_NONE;
		base = cur_q.address & ~PAGE_MASK;
		span_diff = highest_q - lowest_q;
	end

	// Compare the stored segment that was read last cycle.
	always_comb begin
		ent_hit = (cur_q.address[63:PAGE_BITS] < rd_q.page_limit) &&
			(rd_q.page_first < rend_q[63:PAGE_BITS]);
		fin_hit = (entry_point_q >= rd_q.start) && ((entry_point_q - rd_q.start) < rd_q.length);
		scan_done = !cmp_vld_q && (rd_idx_q >= total_q);
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (head_valid && out_free) begin
					case (head.kind)
						ACT_HEADER: st_d = ST_HDR;
						ACT_ENTRY: st_d = (active && head.loadable) ? ST_ENT : ST_IDLE;
						ACT_FINISH: st_d = active ? ST_FIN : ST_IDLE;
						default: st_d = ST_IDLE;
					endcase
				end
			end
			ST_HDR: st_d = ST_IDLE;
			ST_ENT: st_d = (ent_err != ERR_NONE) ? ST_IDLE : ST_RND;
			ST_RND: st_d = (rnd_err != ERR_NONE) ? ST_IDLE : ST_SCAN;
			ST_SCAN: st_d = ((cmp_vld_q && ent_hit) || scan_done) ? ST_IDLE : ST_SCAN;
			ST_FIN: st_d = (total_q == '0 || span_diff > cfg.span_limit) ? ST_IDLE : ST_FSCAN;
			ST_FSCAN: st_d = ((cmp_vld_q && fin_hit) || scan_done) ? ST_IDLE : ST_FSCAN;
			default: st_d = ST_IDLE;
		endcase
	end

	// Control outputs of each state.
	always_comb begin
		ctl = '0;
		ctl.err = ERR_NONE;
		case (st_q)
			ST_IDLE: begin
				ctl.pop = head_valid && out_free;
				ctl.run_done = head.kind == ACT_FINISH;
				case (head.kind)
					ACT_HEADER: ctl.emit = 1'b0;
					ACT_ENTRY: ctl.emit = ctl.pop && !(active && head.loadable);
					ACT_FINISH: ctl.emit = ctl.pop && !active;
					default: ctl.emit = ctl.pop;
				endcase
			end
			ST_HDR: begin
				ctl.emit = 1'b1;
				ctl.clear_run = 1'b1;
				ctl.set_err = hdr_err != ERR_NONE;
				ctl.err = hdr_err;
			end
			ST_ENT: begin
				ctl.emit = ent_err != ERR_NONE;
				ctl.set_err = ctl.emit;
				ctl.err = ent_err;
			end
			ST_RND: begin
				if (rnd_err != ERR_NONE) begin
					ctl.emit = 1'b1;
					ctl.set_err = 1'b1;
					ctl.err = rnd_err;
				end
			end
			ST_SCAN: begin
				if (cmp_vld_q && ent_hit) begin
					ctl.emit = 1'b1;
					ctl.set_err = 1'b1;
					ctl.err = ERR_OVERLAP;
				end else if (scan_done) begin
					ctl.emit = 1'b1;
					ctl.store = 1'b1;
				end
			end
			ST_FIN: begin
				ctl.run_done = 1'b1;
				if (total_q == '0) begin
					ctl.emit = 1'b1;
					ctl.set_err = 1'b1;
					ctl.err = ERR_NO_SEGMENTS;
				end else if (span_diff > cfg.span_limit) begin
					ctl.emit = 1'b1;
					ctl.set_err = 1'b1;
					ctl.err = ERR_SPAN;
				end
			end
			ST_FSCAN: begin
				ctl.run_done = 1'b1;
				if (cmp_vld_q && fin_hit) begin
					ctl.emit = 1'b1;
				end else if (scan_done) begin
					ctl.emit = 1'b1;
					ctl.set_err = 1'b1;
					ctl.err = ERR_ENTRY_POINT;
				end
			end
			default: ctl = '0;
		endcase
	end

	assign head_pop = ctl.pop;

	// Run state after this cycle's update.
	always_comb begin
		sticky_n = sticky_q;
		total_n = total_q;
		lowest_n = lowest_q;
		highest_n = highest_q;
		if (ctl.clear_run) begin
			sticky_n = 5'd0;
			total_n = '0;
			lowest_n = '1;
			highest_n = '0;
		end
		if (ctl.set_err) begin
			sticky_n = ctl.err;
		end
		if (ctl.store) begin
			total_n = total_q + CW'(1);
			if (base < lowest_q) lowest_n = base;
			if (rend_q > highest_q) highest_n = rend_q;
		end
	end

	// Segment store, written at the fill position and read during scans.
	always_ff @(posedge clk) begin
		if (ctl.store) begin
			seg_mem[total_q[IW-1:0]] <= '{page_first: cur_q.address[63:PAGE_BITS],
				page_limit: rend_q[63:PAGE_BITS], start: cur_q.address,
				length: cur_q.mem_size};
		end
		if ((st_q == ST_SCAN || st_q == ST_FSCAN) && rd_idx_q < total_q) begin
			rd_q <= seg_mem[rd_idx_q[IW-1:0]];
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			cur_q <= head.item;
		end
		if (st_q == ST_ENT) begin
			mem_sum_q <= mem_sum;
		end
		if (st_q == ST_RND) begin
			rend_q <= rnd_sum[63:0] & ~PAGE_MASK;
		end
		if (ctl.emit) begin
			out_q.status <= sticky_n;
			out_q.run_done <= ctl.run_done;
			out_q.accepted <= ctl.store;
			out_q.load_base <= ctl.store ? base : 64'd0;
			out_q.load_end <= ctl.store ? rend_q : 64'd0;
			out_q.span_base <= lowest_n;
			out_q.span_end <= highest_n;
			out_q.segment_count <= 5'(total_n);
		end
	end

	// Control and run state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			total_q <= '0;
			lowest_q <= '1;
			highest_q <= '0;
			entry_point_q <= '0;
			sticky_q <= 5'd0;
			header_valid_q <= 1'b0;
			rd_idx_q <= '0;
			cmp_vld_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			sticky_q <= sticky_n;
			total_q <= total_n;
			lowest_q <= lowest_n;
			highest_q <= highest_n;
			if (ctl.clear_run) begin
				header_valid_q <= !ctl.set_err;
				entry_point_q <= ctl.set_err ? 64'd0 : cur_q.address;
			end
			// Scan pointer walks one stored segment per cycle.
			if (st_q == ST_SCAN || st_q == ST_FSCAN) begin
				cmp_vld_q <= rd_idx_q < total_q;
				if (rd_idx_q < total_q) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
			end else begin
				cmp_vld_q <= 1'b0;
				rd_idx_q <= '0;
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.store |-> total_q < MAX_COUNT)
		else $error("segment stored into a full store");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!out_valid_q || !out_stall))
		else $error("result written over one still waiting");
	a_accept_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && ctl.store) |=> (out_data.status == 5'd0 && out_data.accepted))
		else $error("stored segment reported with an error");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_q |-> rd_idx_q <= total_q)
		else $error("scan compared past the fill position");

endmodule
`default_nettype wire

@@ design/elf64_load_segment_checker_unit.sv @@
// An ignored request is answered as it leaves the queue; a header, or an entry failing its
// size or bound checks, after its check state; a page-end overflow after the rounding state;
// a finish failing its count or span check after its check state; other entries and
// finishes after a scan of the stored segments. Requests are handled one at a time; the
// store is scanned one entry per cycle through its single read port.
// Reset (arst_n, asynchronous, low) empties the queue and clears the run and control state.
`default_nettype none
module elf64_load_segment_checker_unit
	import elfls_pkg::*;
#(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [63:0] cfg_data
);

	cfg_t cfg_q;
	logic head_valid;
	logic head_pop;
	queue_item_t head;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_length <= 64'd0;
			cfg_q.span_limit <= SPAN_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_IMAGE_LENGTH) cfg_q.image_length <= cfg_data;
			if (cfg_index == CFG_SPAN_LIMIT) cfg_q.span_limit <= cfg_data;
		end
	end

	elfls_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.head_valid(head_valid),
		.head(head),
		.head_pop(head_pop)
	);

	elfls_back #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head_valid(head_valid),
		.head(head),
		.head_pop(head_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule
`default_nettype wire
